### src/cdl_pkg.sv
// Package for the connection demultiplex lookup block.
// Holds field widths, command and result codes, and the shared structs.
// No dependencies.
`default_nettype none

package cdl_pkg;

  localparam int unsigned CMD_W        = 2;
  localparam int unsigned SLOT_FIELD_W = 4;
  localparam int unsigned POS_FIELD_W  = 3;
  localparam int unsigned FILL_W       = 4;
  localparam int unsigned PORT_W       = 16;
  localparam int unsigned IP_W         = 32;
  localparam int unsigned KIND_W       = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP   = 2'd0,
    CMD_WR_SLOT  = 2'd1,
    CMD_WR_PEND  = 2'd2,
    CMD_SET_RING = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ESTABLISHED = 2'd0,
    KIND_HALF_OPEN   = 2'd1,
    KIND_LISTENER    = 2'd2,
    KIND_NONE        = 2'd3
  } kind_t;

  // Local port plus remote endpoint, used both as a search key and as table contents.
  typedef struct packed {
    logic [PORT_W-1:0] local_port;
    logic [IP_W-1:0]   peer_ip;
    logic [PORT_W-1:0] peer_udp_port;
  } key_t;

  // Status of the shared compare unit.
  typedef struct packed {
    logic port_eq;
    logic peer_eq;
  } match_flags_t;

endpackage

`default_nettype wire

### src/cdl_if.sv
// Valid/ready channel interfaces for segment commands and lookup results.
// Depends on cdl_pkg for field widths.
`default_nettype none

interface cdl_in_if;
  logic                             valid;
  logic                             ready;
  logic [cdl_pkg::CMD_W-1:0]        cmd;
  logic [cdl_pkg::SLOT_FIELD_W-1:0] slot;
  logic [cdl_pkg::POS_FIELD_W-1:0]  queue_pos;
  logic [cdl_pkg::FILL_W-1:0]       queue_fill;
  logic                             entry_valid;
  logic                             entry_listening;
  logic [cdl_pkg::PORT_W-1:0]       local_port;
  logic [cdl_pkg::IP_W-1:0]         peer_ip;
  logic [cdl_pkg::PORT_W-1:0]       peer_udp_port;

  modport source (
    output valid, cmd, slot, queue_pos, queue_fill, entry_valid, entry_listening,
           local_port, peer_ip, peer_udp_port,
    input  ready
  );
  modport sink (
    input  valid, cmd, slot, queue_pos, queue_fill, entry_valid, entry_listening,
           local_port, peer_ip, peer_udp_port,
    output ready
  );
endinterface

interface cdl_out_if;
  logic                             valid;
  logic                             ready;
  logic [cdl_pkg::KIND_W-1:0]       match_kind;
  logic [cdl_pkg::SLOT_FIELD_W-1:0] match_slot;
  logic [cdl_pkg::POS_FIELD_W-1:0]  match_position;

  modport source (
    output valid, match_kind, match_slot, match_position,
    input  ready
  );
  modport sink (
    input  valid, match_kind, match_slot, match_position,
    output ready
  );
endinterface

`default_nettype wire

### src/connection_demux_lookup_unit.sv
// Lookup: a slot scan, then ring setup and a scan of the chosen listener's ring, then the
// result transfer; the ring scan is skipped with no listener or an empty ring, and an
// established hit ends the slot scan early; write commands give no result.
// Throughput: one item at a time, set by the slot scan and ring scan that both feed one
// shared compare unit. Synchronous active-low reset clears valid/listen bits, ring heads
// and counts at once; endpoint fields are undefined until written, so no sweep is run.
`default_nettype none

module connection_demux_lookup_unit #(
  parameter int unsigned CONNECTIONS = 16,
  parameter int unsigned BACKLOG     = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  cdl_in_if.sink     in_if,
  cdl_out_if.source  out_if
);

  localparam int unsigned SLOT_W = $clog2(CONNECTIONS);
  localparam int unsigned POS_W  = $clog2(BACKLOG);
  localparam int unsigned CNT_W  = $clog2(BACKLOG + 1);

  // The sequencer walks one item through slot scan, ring setup and ring scan.
  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_SLOT      = 5'b00010,
    ST_RING_INIT = 5'b00100,
    ST_RING      = 5'b01000,
    ST_DONE      = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  cdl_pkg::key_t     key_r, key_nxt;
  logic [SLOT_W-1:0] ptr_r, ptr_nxt;
  logic              issue_on_r, issue_on_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic              chk_last_r, chk_last_nxt;
  logic [SLOT_W-1:0] chk_idx_r, chk_idx_nxt;
  logic [POS_W-1:0]  chk_pos_r, chk_pos_nxt;
  logic              have_lis_r, have_lis_nxt;
  logic [SLOT_W-1:0] lis_r, lis_nxt;
  logic [POS_W-1:0]  rpos_r, rpos_nxt;
  logic [CNT_W-1:0]  rleft_r, rleft_nxt;

  cdl_pkg::kind_t    res_kind_r, res_kind_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [POS_W-1:0]  res_pos_r, res_pos_nxt;

  logic                             out_valid_r, out_valid_nxt;
  cdl_pkg::kind_t                   out_kind_r, out_kind_nxt;
  logic [cdl_pkg::SLOT_FIELD_W-1:0] out_slot_r, out_slot_nxt;
  logic [cdl_pkg::POS_FIELD_W-1:0]  out_pos_r, out_pos_nxt;

  logic                  in_xfer;
  logic                  slot_ok;
  logic [SLOT_W-1:0]     wr_slot;
  cdl_pkg::key_t         in_key;
  cdl_pkg::key_t         slot_key;
  logic                  slot_valid;
  logic                  slot_listening;
  logic [POS_W-1:0]      ring_head;
  logic [CNT_W-1:0]      ring_count;
  logic [cdl_pkg::IP_W-1:0]   ring_ip;
  logic [cdl_pkg::PORT_W-1:0] ring_uport;
  cdl_pkg::key_t         cand;
  cdl_pkg::match_flags_t flags;

  // Input side: a transfer is taken only while the sequencer is idle.
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_if.valid && in_if.ready;

  // A slot number past the table is dropped by all write commands.
  assign slot_ok = (32'(in_if.slot) < CONNECTIONS);
  assign wr_slot = SLOT_W'(in_if.slot);

  assign in_key.local_port    = in_if.local_port;
  assign in_key.peer_ip       = in_if.peer_ip;
  assign in_key.peer_udp_port = in_if.peer_udp_port;

  cdl_slot_mem #(
    .CONNECTIONS (CONNECTIONS)
  ) u_slot_mem (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr_en          (in_xfer && (in_if.cmd == cdl_pkg::CMD_WR_SLOT) && slot_ok),
    .wr_idx         (wr_slot),
    .wr_valid       (in_if.entry_valid),
    .wr_listening   (in_if.entry_listening),
    .wr_key         (in_key),
    .rd_idx         (ptr_r),
    .rd_key_r       (slot_key),
    .rd_valid_r     (slot_valid),
    .rd_listening_r (slot_listening)
  );

  // Ring writes address the slot from the command; head, count and ring reads
  // are all steered to the chosen listener.
  cdl_ring_mem #(
    .CONNECTIONS (CONNECTIONS),
    .BACKLOG     (BACKLOG)
  ) u_ring_mem (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_entry_en (in_xfer && (in_if.cmd == cdl_pkg::CMD_WR_PEND) && slot_ok),
    .wr_ring_en  (in_xfer && (in_if.cmd == cdl_pkg::CMD_SET_RING) && slot_ok),
    .wr_slot     (in_xfer ? wr_slot : lis_r),
    .wr_pos      (in_if.queue_pos),
    .wr_fill     (in_if.queue_fill),
    .wr_ip       (in_if.peer_ip),
    .wr_uport    (in_if.peer_udp_port),
    .sel_slot    (in_xfer ? wr_slot : lis_r),
    .sel_head    (ring_head),
    .sel_count   (ring_count),
    .rd_pos      (rpos_r),
    .rd_ip_r     (ring_ip),
    .rd_uport_r  (ring_uport)
  );

  // During the ring scan the port is already known to match the listener, so
  // the candidate borrows the key's port and only the peer compare matters.
  always_comb begin
    cand = slot_key;
    if (state_r == ST_RING) begin
      cand.local_port    = key_r.local_port;
      cand.peer_ip       = ring_ip;
      cand.peer_udp_port = ring_uport;
    end
  end

  cdl_match u_match (
    .key   (key_r),
    .cand  (cand),
    .flags (flags)
  );

  // Sequencer. Reads are issued in the cycle before their compare, so each scan
  // phase runs one memory read and one compare per cycle.
  always_comb begin
    state_nxt    = state_r;
    key_nxt      = key_r;
    ptr_nxt      = ptr_r;
    issue_on_nxt = issue_on_r;
    chk_vld_nxt  = chk_vld_r;
    chk_last_nxt = chk_last_r;
    chk_idx_nxt  = chk_idx_r;
    chk_pos_nxt  = chk_pos_r;
    have_lis_nxt = have_lis_r;
    lis_nxt      = lis_r;
    rpos_nxt     = rpos_r;
    rleft_nxt    = rleft_r;
    res_kind_nxt = res_kind_r;
    res_slot_nxt = res_slot_r;
    res_pos_nxt  = res_pos_r;

    // The output register frees as soon as the sink takes its transfer.
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_pos_nxt   = out_pos_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_if.cmd == cdl_pkg::CMD_LOOKUP)) begin
          key_nxt      = in_key;
          ptr_nxt      = '0;
          issue_on_nxt = 1'b1;
          chk_vld_nxt  = 1'b0;
          have_lis_nxt = 1'b0;
          state_nxt    = ST_SLOT;
        end
      end

      ST_SLOT: begin
        if (issue_on_r) begin
          chk_vld_nxt  = 1'b1;
          chk_idx_nxt  = ptr_r;
          chk_last_nxt = (ptr_r == SLOT_W'(CONNECTIONS - 1));
          if (ptr_r == SLOT_W'(CONNECTIONS - 1)) begin
            issue_on_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end else begin
          chk_vld_nxt = 1'b0;
        end

        if (chk_vld_r) begin
          if (slot_valid && flags.port_eq && flags.peer_eq) begin
            // The lowest fully matching slot wins at once.
            res_kind_nxt = cdl_pkg::KIND_ESTABLISHED;
            res_slot_nxt = chk_idx_r;
            res_pos_nxt  = '0;
            state_nxt    = ST_DONE;
          end else begin
            // Later listeners overwrite earlier ones: the highest index is kept.
            if (slot_valid && flags.port_eq && slot_listening) begin
              have_lis_nxt = 1'b1;
              lis_nxt      = chk_idx_r;
            end
            if (chk_last_r) begin
              state_nxt = ST_RING_INIT;
            end
          end
        end
      end

      ST_RING_INIT: begin
        chk_vld_nxt = 1'b0;
        if (!have_lis_r) begin
          res_kind_nxt = cdl_pkg::KIND_NONE;
          res_slot_nxt = '0;
          res_pos_nxt  = '0;
          state_nxt    = ST_DONE;
        end else if (ring_count == '0) begin
          res_kind_nxt = cdl_pkg::KIND_LISTENER;
          res_slot_nxt = lis_r;
          res_pos_nxt  = '0;
          state_nxt    = ST_DONE;
        end else begin
          rpos_nxt  = ring_head;
          rleft_nxt = ring_count;
          state_nxt = ST_RING;
        end
      end

      ST_RING: begin
        if (rleft_r != '0) begin
          chk_vld_nxt  = 1'b1;
          chk_pos_nxt  = rpos_r;
          chk_last_nxt = (rleft_r == CNT_W'(1));
          rleft_nxt    = rleft_r - 1'b1;
          rpos_nxt     = (rpos_r == POS_W'(BACKLOG - 1)) ? '0 : rpos_r + 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
        end

        if (chk_vld_r) begin
          if (flags.peer_eq) begin
            res_kind_nxt = cdl_pkg::KIND_HALF_OPEN;
            res_slot_nxt = lis_r;
            res_pos_nxt  = chk_pos_r;
            state_nxt    = ST_DONE;
          end else if (chk_last_r) begin
            res_kind_nxt = cdl_pkg::KIND_LISTENER;
            res_slot_nxt = lis_r;
            res_pos_nxt  = '0;
            state_nxt    = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_slot_nxt  = cdl_pkg::SLOT_FIELD_W'(res_slot_r);
          out_pos_nxt   = cdl_pkg::POS_FIELD_W'(res_pos_r);
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_on_r  <= 1'b0;
      chk_vld_r   <= 1'b0;
      have_lis_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_on_r  <= issue_on_nxt;
      chk_vld_r   <= chk_vld_nxt;
      have_lis_r  <= have_lis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and payload registers.
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    ptr_r      <= ptr_nxt;
    chk_last_r <= chk_last_nxt;
    chk_idx_r  <= chk_idx_nxt;
    chk_pos_r  <= chk_pos_nxt;
    lis_r      <= lis_nxt;
    rpos_r     <= rpos_nxt;
    rleft_r    <= rleft_nxt;
    res_kind_r <= res_kind_nxt;
    res_slot_r <= res_slot_nxt;
    res_pos_r  <= res_pos_nxt;
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_pos_r  <= out_pos_nxt;
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.match_kind     = out_kind_r;
  assign out_if.match_slot     = out_slot_r;
  assign out_if.match_position = out_pos_r;

endmodule

`default_nettype wire

### src/cdl_match.sv
// Shared compare unit: checks a candidate entry against the search key.
// Depends on cdl_pkg for key_t and match_flags_t.
`default_nettype none

module cdl_match (
  input  cdl_pkg::key_t         key,
  input  cdl_pkg::key_t         cand,
  output cdl_pkg::match_flags_t flags
);

  assign flags.port_eq = (key.local_port == cand.local_port);
  assign flags.peer_eq = (key.peer_ip == cand.peer_ip) &&
                         (key.peer_udp_port == cand.peer_udp_port);

endmodule

`default_nettype wire

### src/cdl_slot_mem.sv
// Connection slot table: valid and listen bits in flops, endpoint fields in a memory.
// Depends on cdl_pkg for key_t.
`default_nettype none

module cdl_slot_mem #(
  parameter int unsigned CONNECTIONS = 16,
  localparam int unsigned SLOT_W     = $clog2(CONNECTIONS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_idx,
  input  logic              wr_valid,
  input  logic              wr_listening,
  input  cdl_pkg::key_t     wr_key,
  input  logic [SLOT_W-1:0] rd_idx,
  output cdl_pkg::key_t     rd_key_r,
  output logic              rd_valid_r,
  output logic              rd_listening_r
);

  cdl_pkg::key_t    mem [CONNECTIONS];
  logic [CONNECTIONS-1:0] valid_r;
  logic [CONNECTIONS-1:0] listening_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      listening_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx]     <= wr_valid;
      listening_r[wr_idx] <= wr_listening;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_key;
    end
    rd_key_r <= mem[rd_idx];
  end

  // Flag reads are registered alongside the memory read so they line up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r     <= 1'b0;
      rd_listening_r <= 1'b0;
    end else begin
      rd_valid_r     <= valid_r[rd_idx];
      rd_listening_r <= listening_r[rd_idx];
    end
  end

endmodule

`default_nettype wire

### src/cdl_ring_mem.sv
// Pending half-open peer rings: one ring per slot in a memory, head and count in flops.
// Depends on cdl_pkg for field widths.
`default_nettype none

module cdl_ring_mem #(
  parameter int unsigned CONNECTIONS = 16,
  parameter int unsigned BACKLOG     = 8,
  localparam int unsigned SLOT_W     = $clog2(CONNECTIONS),
  localparam int unsigned POS_W      = $clog2(BACKLOG),
  localparam int unsigned CNT_W      = $clog2(BACKLOG + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_entry_en,
  input  logic                               wr_ring_en,
  input  logic [SLOT_W-1:0]                  wr_slot,
  input  logic [cdl_pkg::POS_FIELD_W-1:0]    wr_pos,
  input  logic [cdl_pkg::FILL_W-1:0]         wr_fill,
  input  logic [cdl_pkg::IP_W-1:0]           wr_ip,
  input  logic [cdl_pkg::PORT_W-1:0]         wr_uport,
  input  logic [SLOT_W-1:0]                  sel_slot,
  output logic [POS_W-1:0]                   sel_head,
  output logic [CNT_W-1:0]                   sel_count,
  input  logic [POS_W-1:0]                   rd_pos,
  output logic [cdl_pkg::IP_W-1:0]           rd_ip_r,
  output logic [cdl_pkg::PORT_W-1:0]         rd_uport_r
);

  localparam int unsigned ENTRY_W = cdl_pkg::IP_W + cdl_pkg::PORT_W;

  logic [ENTRY_W-1:0]              mem [CONNECTIONS][BACKLOG];
  logic [POS_W-1:0]                head_r  [CONNECTIONS];
  logic [CNT_W-1:0]                count_r [CONNECTIONS];
  logic [cdl_pkg::POS_FIELD_W-1:0] head_mod;
  logic [CNT_W-1:0]                fill_sat;
  logic                            pos_ok;

  // The head wraps onto the ring; the field is narrow, so three conditional
  // subtractions reduce it for any ring depth above one.
  always_comb begin
    head_mod = wr_pos;
    for (int k = 0; k < 3; k++) begin
      if (32'(head_mod) >= BACKLOG) begin
        head_mod = head_mod - cdl_pkg::POS_FIELD_W'(BACKLOG);
      end
    end
  end

  assign fill_sat = (32'(wr_fill) > BACKLOG) ? CNT_W'(BACKLOG) : CNT_W'(wr_fill);
  assign pos_ok   = (32'(wr_pos) < BACKLOG);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CONNECTIONS; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else if (wr_ring_en) begin
      head_r[wr_slot]  <= POS_W'(head_mod);
      count_r[wr_slot] <= fill_sat;
    end
  end

  assign sel_head  = head_r[sel_slot];
  assign sel_count = count_r[sel_slot];

  always_ff @(posedge clk) begin
    if (wr_entry_en && pos_ok) begin
      mem[wr_slot][POS_W'(wr_pos)] <= {wr_ip, wr_uport};
    end
    {rd_ip_r, rd_uport_r} <= mem[sel_slot][rd_pos];
  end

endmodule

`default_nettype wire

### src/cdl_checker.sv
// Port-level checker for connection_demux_lookup_unit, attached with a bind.
// Depends on cdl_pkg for command and result codes.
`default_nettype none

module cdl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [cdl_pkg::CMD_W-1:0]        in_cmd,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [cdl_pkg::KIND_W-1:0]       out_match_kind,
  input logic [cdl_pkg::SLOT_FIELD_W-1:0] out_match_slot,
  input logic [cdl_pkg::POS_FIELD_W-1:0]  out_match_position
);

  // A stalled result holds until the sink takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_match_kind) &&
      $stable(out_match_slot) && $stable(out_match_position))
    else $error("result changed while stalled");

  // A lookup occupies the block: no new transfer in the next cycle.
  a_busy_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == cdl_pkg::CMD_LOOKUP) |=> !in_ready)
    else $error("input ready right after a lookup transfer");

  // A write command never produces a result.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd != cdl_pkg::CMD_LOOKUP) && !out_valid |=> !out_valid)
    else $error("result appeared after a write command");

  // Only a half-open result carries a ring position, and none carries no slot.
  a_result_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_match_kind != cdl_pkg::KIND_HALF_OPEN) |->
      (out_match_position == '0) &&
      ((out_match_kind != cdl_pkg::KIND_NONE) || (out_match_slot == '0)))
    else $error("result fields inconsistent with match kind");

endmodule

bind connection_demux_lookup_unit cdl_checker u_cdl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .in_cmd             (in_if.cmd),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .out_match_kind     (out_if.match_kind),
  .out_match_slot     (out_if.match_slot),
  .out_match_position (out_if.match_position)
);

`default_nettype wire
